[hw/rtl/sqmm_pkg.sv]
// types and constants for the square matrix multiply core
// no dependencies

package sqmm_pkg;

    localparam int ELEM_W    = 32;
    localparam int IDX_W     = 3;
    localparam int SIZE_W    = 4;
    localparam int FRAC_BITS = 16;
    localparam int PROD_W    = 2 * ELEM_W;
    localparam int ACC_W     = PROD_W - FRAC_BITS + 4;
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd8;
    localparam logic [0:0]        REG_SIZE_IN_USE = 1'b0;

    localparam logic signed [ELEM_W-1:0] ELEM_MAX = {1'b0, {(ELEM_W-1){1'b1}}};
    localparam logic signed [ELEM_W-1:0] ELEM_MIN = {1'b1, {(ELEM_W-1){1'b0}}};

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic signed [ELEM_W-1:0] elem_t;

endpackage

[hw/rtl/square_matrix_multiply_core.sv]
// square matrix multiply core: C = A * B on signed Q16.16 elements, depends on sqmm_pkg
// each element: RUN reads one operand pair per k, then DRAIN waits for the pipeline to empty and the output to be free
// one load item per cycle while idle; load items are refused during a product run
// products come from a single shared multiply-accumulate with a 3-stage pipeline
// operand stores are synchronous memories, undefined until written
// rst_n async active low clears control state and sets size_in_use to 8

module square_matrix_multiply_core
    import sqmm_pkg::*;
#(
    parameter int MAX_DIM = 8
)
(
    input  logic               clk,
    input  logic               rst_n,

    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,

    input  logic               in_valid,
    output logic               in_ready,
    input  logic               matrix_select,
    input  idx_t               row_index,
    input  idx_t               col_index,
    input  elem_t              element_value,
    input  logic               start_multiply,

    output logic               out_valid,
    input  logic               out_ready,
    output elem_t              product_value,
    output idx_t               out_row,
    output idx_t               out_col,
    output logic               saturated,
    output logic               last_result
);

    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = $clog2(DEPTH);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN
    } state_t;

    state_t            state_reg;
    logic [SIZE_W-1:0] size_reg;
    idx_t              i_reg;
    idx_t              j_reg;
    idx_t              k_reg;
    logic              s1_valid_reg;
    logic              s1_last_reg;
    logic              s2_valid_reg;
    logic              s2_last_reg;
    logic              done_reg;
    logic              out_valid_reg;

    elem_t                    left_mem [DEPTH];
    elem_t                    right_mem [DEPTH];
    elem_t                    a_q_reg;
    elem_t                    b_q_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    elem_t                    value_reg;
    idx_t                     row_reg;
    idx_t                     col_reg;
    logic                     sat_reg;
    logic                     last_reg;

    logic                     cfg_write;
    logic                     in_fire;
    logic                     wr_ok;
    logic [ADDR_W-1:0]        wr_addr;
    logic [ADDR_W-1:0]        addr_a;
    logic [ADDR_W-1:0]        addr_b;
    logic                     rd_en;
    idx_t                     last_idx;
    logic                     k_last;
    logic                     emit;
    logic                     acc_clear;
    logic signed [PROD_W-1:0] prod_shift;
    logic                     fits;
    elem_t                    sat_value;

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[PADDR_W-1:2] == REG_SIZE_IN_USE)
                       ? PDATA_W'(size_reg) : '0;

    always_comb
    begin
        if (size_reg == '0)
        begin
            last_idx = '0;
        end
        else if (size_reg > SIZE_W'(MAX_DIM))
        begin
            last_idx = IDX_W'(MAX_DIM - 1);
        end
        else
        begin
            last_idx = IDX_W'(size_reg - 1'b1);
        end
    end

    assign in_ready = (state_reg == ST_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign wr_ok    = (int'(row_index) < MAX_DIM) && (int'(col_index) < MAX_DIM);
    assign wr_addr  = ADDR_W'(int'(row_index) * MAX_DIM + int'(col_index));
    assign addr_a   = ADDR_W'(int'(i_reg) * MAX_DIM + int'(k_reg));
    assign addr_b   = ADDR_W'(int'(k_reg) * MAX_DIM + int'(j_reg));
    assign rd_en    = (state_reg == ST_RUN);
    assign k_last   = (k_reg == last_idx);
    assign emit     = (state_reg == ST_DRAIN) && done_reg && (!out_valid_reg || out_ready);
    assign acc_clear = emit || in_fire;

    // operand memories
    always_ff @(posedge clk)
    begin
        if (in_fire && wr_ok && !matrix_select)
        begin
            left_mem[wr_addr] <= element_value;
        end
        if (rd_en)
        begin
            a_q_reg <= left_mem[addr_a];
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && wr_ok && matrix_select)
        begin
            right_mem[wr_addr] <= element_value;
        end
        if (rd_en)
        begin
            b_q_reg <= right_mem[addr_b];
        end
    end

    // multiply-accumulate datapath
    assign prod_shift = prod_reg >>> FRAC_BITS;

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            prod_reg <= a_q_reg * b_q_reg;
        end
        if (acc_clear)
        begin
            acc_reg <= '0;
        end
        else if (s2_valid_reg)
        begin
            acc_reg <= acc_reg + prod_shift[ACC_W-1:0];
        end
    end

    assign fits      = (acc_reg[ACC_W-1:ELEM_W-1] == {(ACC_W-ELEM_W+1){acc_reg[ELEM_W-1]}});
    assign sat_value = fits ? acc_reg[ELEM_W-1:0] : (acc_reg[ACC_W-1] ? ELEM_MIN : ELEM_MAX);

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            value_reg <= sat_value;
            row_reg   <= i_reg;
            col_reg   <= j_reg;
            sat_reg   <= !fits;
            last_reg  <= (i_reg == last_idx) && (j_reg == last_idx);
        end
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            size_reg      <= SIZE_RESET;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            s1_valid_reg  <= 1'b0;
            s1_last_reg   <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s2_last_reg   <= 1'b0;
            done_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write && (paddr[PADDR_W-1:2] == REG_SIZE_IN_USE))
            begin
                size_reg <= pwdata[SIZE_W-1:0];
            end

            s1_valid_reg <= rd_en;
            s1_last_reg  <= rd_en && k_last;
            s2_valid_reg <= s1_valid_reg;
            s2_last_reg  <= s1_valid_reg && s1_last_reg;

            if (emit)
            begin
                done_reg <= 1'b0;
            end
            else if (s2_valid_reg && s2_last_reg)
            begin
                done_reg <= 1'b1;
            end

            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire && start_multiply)
                    begin
                        i_reg     <= '0;
                        j_reg     <= '0;
                        k_reg     <= '0;
                        state_reg <= ST_RUN;
                    end
                end
                ST_RUN:
                begin
                    if (k_last)
                    begin
                        k_reg     <= '0;
                        state_reg <= ST_DRAIN;
                    end
                    else
                    begin
                        k_reg <= k_reg + 1'b1;
                    end
                end
                ST_DRAIN:
                begin
                    if (emit)
                    begin
                        if (j_reg == last_idx)
                        begin
                            j_reg <= '0;
                            if (i_reg == last_idx)
                            begin
                                state_reg <= ST_IDLE;
                            end
                            else
                            begin
                                i_reg     <= i_reg + 1'b1;
                                state_reg <= ST_RUN;
                            end
                        end
                        else
                        begin
                            j_reg     <= j_reg + 1'b1;
                            state_reg <= ST_RUN;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid     = out_valid_reg;
    assign product_value = value_reg;
    assign out_row       = row_reg;
    assign out_col       = col_reg;
    assign saturated     = sat_reg;
    assign last_result   = last_reg;

`ifndef SYNTHESIS
    a_pipe_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> !s1_valid_reg && !s2_valid_reg && !done_reg)
        else $error("mac pipeline busy while idle");

    a_emit_drained: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> !s1_valid_reg && !s2_valid_reg)
        else $error("element emitted before accumulation finished");

    a_k_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_RUN |-> k_reg <= last_idx)
        else $error("inner index beyond active size");

    a_last_corner: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && last_reg |-> row_reg == col_reg && row_reg == last_idx)
        else $error("last item not at the final corner");

    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        emit && (i_reg == last_idx) && (j_reg == last_idx) |=> state_reg == ST_IDLE)
        else $error("run did not end after the final element");
`endif

endmodule
